FILE: hw/rtl/met_pkg.sv
// shared types, constants and helper functions for the escape-time pixel engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

  localparam int CfgIdxW = 3;
  localparam int PalDepth = 40;

  localparam logic [CfgIdxW-1:0] CFG_CENTER_REAL    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_IMAG    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_STEP     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ITERATIONS = 3'd5;

  typedef struct packed {
    logic signed [31:0] center_real;
    logic signed [31:0] center_imag;
    logic [30:0]        pixel_step;
    logic [10:0]        image_width;
    logic [10:0]        image_height;
    logic [15:0]        max_iterations;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // entries past the table read as black
  function automatic logic [23:0] palette_rgb(input logic [7:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      8'd0:  rgb = 24'hFFB404;
      8'd1:  rgb = 24'hF09C04;
      8'd2:  rgb = 24'hDC7C04;
      8'd3:  rgb = 24'h9C4704;
      8'd4:  rgb = 24'h481404;
      8'd5:  rgb = 24'hFBB404;
      8'd6:  rgb = 24'hB44A04;
      8'd7:  rgb = 24'hB44604;
      8'd8:  rgb = 24'hA45B04;
      8'd9:  rgb = 24'h641C04;
      8'd10: rgb = 24'hBF5204;
      8'd11: rgb = 24'h2F0504;
      8'd12: rgb = 24'h8A2704;
      8'd13: rgb = 24'h511B04;
      8'd14: rgb = 24'hC05904;
      8'd15: rgb = 24'h3D1B04;
      8'd16: rgb = 24'hD89404;
      8'd17: rgb = 24'h470E04;
      8'd18: rgb = 24'h8E3004;
      8'd19: rgb = 24'hC46604;
      8'd20: rgb = 24'h3A0904;
      8'd21: rgb = 24'h842D04;
      8'd22: rgb = 24'h5F0F04;
      8'd23: rgb = 24'h5C1504;
      8'd24: rgb = 24'hA63B04;
      8'd25: rgb = 24'hF4B204;
      8'd26: rgb = 24'hC27904;
      8'd27: rgb = 24'h782904;
      8'd28: rgb = 24'h350E04;
      8'd29: rgb = 24'h500F04;
      8'd30: rgb = 24'h170304;
      8'd31: rgb = 24'hF9CC04;
      8'd32: rgb = 24'h611904;
      8'd33: rgb = 24'h7C1E04;
      8'd34: rgb = 24'h973904;
      8'd35: rgb = 24'h682404;
      8'd36: rgb = 24'hEFAB04;
      8'd37: rgb = 24'h833904;
      8'd38: rgb = 24'h6F1704;
      8'd39: rgb = 24'h040204;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/met_front.sv
// front end: takes pixel requests and maps them to complex points
// depends on met_pkg; one shared multiplier for real and imaginary parts
`timescale 1ns / 1ps
`default_nettype none

module met_front import met_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  pixel_column,
  input  logic [9:0]  pixel_row,
  input  cfg_t        cfg,
  input  qstat_t      qs,
  output logic        push,
  output point_t      push_data
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_REAL,
    F_IMAG,
    F_PUSH
  } fstate_t;

  fstate_t            state;
  logic [9:0]         col;
  logic [9:0]         row;
  logic signed [43:0] prod;
  logic signed [31:0] cr;

  logic [9:0]         pix;
  logic [10:0]        size;
  logic signed [11:0] twice;
  logic signed [43:0] prod_next;
  logic signed [31:0] centre;
  logic signed [31:0] mapped;

  always_comb begin
    pix    = (state == F_REAL) ? col : row;
    size   = (state == F_REAL) ? cfg.image_width : cfg.image_height;
    twice  = $signed({1'b0, pix, 1'b0}) - $signed({1'b0, size});
    prod_next = 44'(twice) * 44'($signed({1'b0, cfg.pixel_step}));
    centre = (state == F_IMAG) ? cfg.center_real : cfg.center_imag;
    mapped = sat32(66'(centre) + 66'(prod >>> 1));
  end

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !qs.full;
  assign push_data = '{cr: cr, ci: mapped};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start) begin
            col   <= pixel_column;
            row   <= pixel_row;
            state <= F_REAL;
          end
        end
        F_REAL: begin
          prod  <= prod_next;
          state <= F_IMAG;
        end
        F_IMAG: begin
          cr    <= mapped;
          prod  <= prod_next;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!qs.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/met_queue.sv
// two-entry point queue between front end and iteration engine
// depends on met_pkg for the point and status types
`timescale 1ns / 1ps
`default_nettype none

module met_queue import met_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  point_t push_data,
  input  logic   pop,
  output point_t pop_data,
  output qstat_t qs
);

  point_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign qs.full   = (fill == 2'd2);
  assign qs.empty  = (fill == 2'd0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/met_back.sv
// iteration engine: runs z = z*z + c on one point and colours the result
// depends on met_pkg; products registered, then add, compare and saturate
`timescale 1ns / 1ps
`default_nettype none

module met_back import met_pkg::*; #(
  parameter int PALETTE_SIZE = 40,
  parameter int FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] max_iterations,
  input  qstat_t      qs,
  input  point_t      pop_data,
  output logic        pop,
  output logic        done,
  output logic [15:0] escape_count,
  output logic        in_set,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  localparam int PW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [PW-1:0] PalLast = PW'(PALETTE_SIZE - 1);
  localparam logic signed [64:0] Limit = 65'sd4 <<< FRAC_BITS;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_ADD
  } bstate_t;

  bstate_t            state;
  logic signed [31:0] cr;
  logic signed [31:0] ci;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [63:0] pxx;
  logic signed [63:0] pyy;
  logic signed [63:0] pxy;
  logic [15:0]        count;
  logic [PW-1:0]      cmod;

  logic signed [63:0] xx;
  logic signed [63:0] yy;
  logic signed [63:0] xy2;
  logic signed [64:0] mag;
  logic               finish;
  logic signed [31:0] x_next;
  logic signed [31:0] y_next;
  logic [PW-1:0]      cmod_next;
  logic [PW-1:0]      pal_idx;
  logic               member;
  logic [23:0]        rgb;

  always_comb begin
    xx        = pxx >>> FRAC_BITS;
    yy        = pyy >>> FRAC_BITS;
    xy2       = pxy >>> (FRAC_BITS - 1);
    mag       = 65'(xx) + 65'(yy);
    finish    = !(mag < Limit) || (count >= max_iterations);
    x_next    = sat32(66'(xx) - 66'(yy) + 66'(cr));
    y_next    = sat32(66'(xy2) + 66'(ci));
    cmod_next = (cmod == PalLast) ? '0 : cmod + 1'b1;
    pal_idx   = (cmod == '0) ? PalLast : cmod - 1'b1;
    member    = (count == max_iterations);
    rgb       = member ? 24'h000000 : palette_rgb(8'(pal_idx));
  end

  assign pop = (state == B_IDLE) && !qs.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == B_ADD) && finish;
      unique case (state)
        B_IDLE: begin
          if (!qs.empty) begin
            cr    <= pop_data.cr;
            ci    <= pop_data.ci;
            x     <= '0;
            y     <= '0;
            count <= '0;
            cmod  <= '0;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          pxx   <= x * x;
          pyy   <= y * y;
          pxy   <= x * y;
          state <= B_ADD;
        end
        B_ADD: begin
          if (finish) begin
            escape_count <= count;
            in_set       <= member;
            red          <= rgb[23:16];
            green        <= rgb[15:8];
            blue         <= rgb[7:0];
            state        <= B_IDLE;
          end else begin
            x     <= x_next;
            y     <= y_next;
            count <= count + 16'd1;
            cmod  <= cmod_next;
            state <= B_MUL;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mandelbrot_escape_time_pixel.sv
// Escape-time pixel engine. A request (start while busy is low) names a pixel; the front
// end maps it to a complex point on one multiplier, real part then imaginary part, and hands it
// through a two-entry queue to the iteration engine; the front end is then free to take the next request.
// The engine uses one set of three 32x32 multipliers; each iteration passes through a multiply
// state and an add state, so a pixel occupies it longer the higher its escape count; the iteration limit bounds this.
// Each result appears for exactly one cycle with done high and cannot be held off.
// Configuration writes are always taken and must only be made while no pixel is pending.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_pixel import met_pkg::*; #(
  parameter int PALETTE_SIZE = 40,
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         pixel_column,
  input  logic [9:0]         pixel_row,
  output logic               done,
  output logic [15:0]        escape_count,
  output logic               in_set,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t   cfg;
  qstat_t qs;
  logic   push;
  logic   pop;
  point_t push_data;
  point_t pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_real    <= -32'sd188519432;
      cfg.center_imag    <= 32'sd94012716;
      cfg.pixel_step     <= 31'd1533916;
      cfg.image_width    <= 11'd700;
      cfg.image_height   <= 11'd700;
      cfg.max_iterations <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_REAL:    cfg.center_real    <= cfg_data;
        CFG_CENTER_IMAG:    cfg.center_imag    <= cfg_data;
        CFG_PIXEL_STEP:     cfg.pixel_step     <= cfg_data[30:0];
        CFG_IMAGE_WIDTH:    cfg.image_width    <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT:   cfg.image_height   <= cfg_data[10:0];
        CFG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  met_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .cfg          (cfg),
    .qs           (qs),
    .push         (push),
    .push_data    (push_data)
  );

  met_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qs        (qs)
  );

  met_back #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (cfg.max_iterations),
    .qs             (qs),
    .pop_data       (pop_data),
    .pop            (pop),
    .done           (done),
    .escape_count   (escape_count),
    .in_set         (in_set),
    .red            (red),
    .green          (green),
    .blue           (blue)
  );

  a_member_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (in_set == (escape_count == cfg.max_iterations)))
    else $error("member flag disagrees with escape count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (escape_count <= cfg.max_iterations))
    else $error("escape count beyond iteration limit");

  a_member_black: assert property (@(posedge clk) disable iff (rst)
    (done && in_set) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("member pixel not black");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for mandelbrot_escape_time_pixel: directed plan, then random views
// carries its own fixed-point escape-time predictor and palette; depends on met_pkg and the rtl
`timescale 1ns / 1ps

module tb;
  import met_pkg::*;

  localparam int FracBits = 28;
  localparam int PaletteSize = 40;
  localparam int RandomItems = 600;
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 20;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [31:0] WrapCenter = 32'h06000000;
  localparam logic [31:0] WrapStride = 32'd65536;
  localparam logic [31:0] WrapSpan = 32'd1024;
  localparam logic [31:0] WrapLimit = 32'd200;

  localparam logic [23:0] Palette [0:PalDepth-1] = '{
    24'hFFB404, 24'hF09C04, 24'hDC7C04, 24'h9C4704, 24'h481404,
    24'hFBB404, 24'hB44A04, 24'hB44604, 24'hA45B04, 24'h641C04,
    24'hBF5204, 24'h2F0504, 24'h8A2704, 24'h511B04, 24'hC05904,
    24'h3D1B04, 24'hD89404, 24'h470E04, 24'h8E3004, 24'hC46604,
    24'h3A0904, 24'h842D04, 24'h5F0F04, 24'h5C1504, 24'hA63B04,
    24'hF4B204, 24'hC27904, 24'h782904, 24'h350E04, 24'h500F04,
    24'h170304, 24'hF9CC04, 24'h611904, 24'h7C1E04, 24'h973904,
    24'h682404, 24'hEFAB04, 24'h833904, 24'h6F1704, 24'h040204
  };

  typedef struct packed {
    logic [15:0] count;
    logic        member;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_result_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;
  typedef enum logic [1:0] {VIEW_BOUNDARY, VIEW_RAW, VIEW_WRAP} view_t;

  typedef struct {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [31:0]         data;
    logic [9:0]          px_col;
    logic [9:0]          px_row;
    bit                  known;
    pixel_result_t       res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [9:0] pixel_column = '0;
  logic [9:0] pixel_row = '0;
  logic done;
  logic [15:0] escape_count;
  logic in_set;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cfg_t model_cfg;
  pixel_result_t pending_pixels[$];
  plan_row_t plan[$];
  int wrap_cols[$];
  bit pace_gaps = 1'b1;
  int failures = 0;
  int pixels_sent = 0;
  int members_seen = 0;
  int wraps_seen = 0;
  int reg_writes = 0;
  int cycles = 0;

  mandelbrot_escape_time_pixel dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pixel_column(pixel_column),
    .pixel_row(pixel_row),
    .done(done),
    .escape_count(escape_count),
    .in_set(in_set),
    .red(red),
    .green(green),
    .blue(blue),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // centre plus floor((2*pos - size) * stride / 2)
  function automatic longint axis_point(longint centre, longint pos, longint size,
                                        longint stride);
    longint span;
    span = (2 * pos - size) * stride;
    return clamp_s32(centre + (span >>> 1));
  endfunction

  function automatic pixel_result_t predict_pixel(cfg_t c, logic [9:0] col, logic [9:0] row);
    pixel_result_t res;
    longint cr, ci, x, y, xx, yy, xy2;
    longint escape_sq;
    int unsigned count;
    int unsigned slot;
    logic [23:0] rgb;
    cr = axis_point(longint'(signed'(c.center_real)), longint'(col),
                    longint'(c.image_width), longint'(c.pixel_step));
    ci = axis_point(longint'(signed'(c.center_imag)), longint'(row),
                    longint'(c.image_height), longint'(c.pixel_step));
    escape_sq = longint'(4) <<< FracBits;
    x = 0;
    y = 0;
    count = 0;
    while (count < c.max_iterations) begin
      xx = (x * x) >>> FracBits;
      yy = (y * y) >>> FracBits;
      if (xx + yy >= escape_sq) break;
      xy2 = (x * y) >>> (FracBits - 1);
      x = clamp_s32(xx - yy + cr);
      y = clamp_s32(xy2 + ci);
      count++;
    end
    rgb = '0;
    res.member = (count == c.max_iterations);
    if (!res.member) begin
      slot = count % PaletteSize;
      slot = (slot == 0) ? PaletteSize - 1 : slot - 1;
      if (slot < PalDepth) rgb = Palette[slot];
    end
    res.count = count[15:0];
    res.red = rgb[23:16];
    res.green = rgb[15:8];
    res.blue = rgb[7:0];
    return res;
  endfunction

  function automatic plan_row_t plan_write(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    plan_row_t r;
    r = '{kind: ROW_WRITE, idx: idx, data: data, px_col: '0, px_row: '0, known: 1'b0,
          res: '0};
    return r;
  endfunction

  function automatic plan_row_t plan_pixel(logic [9:0] col, logic [9:0] row);
    plan_row_t r;
    r = '{kind: ROW_PIXEL, idx: '0, data: '0, px_col: col, px_row: row, known: 1'b0,
          res: '0};
    return r;
  endfunction

  function automatic plan_row_t plan_known(logic [9:0] col, logic [9:0] row,
                                           logic [15:0] count, logic member,
                                           logic [23:0] rgb);
    plan_row_t r;
    r = plan_pixel(col, row);
    r.known = 1'b1;
    r.res = '{count: count, member: member, red: rgb[23:16], green: rgb[15:8],
              blue: rgb[7:0]};
    return r;
  endfunction

  // called and returns at a falling edge; start is left high
  task automatic issue_pixel(logic [9:0] col, logic [9:0] row, bit known,
                             pixel_result_t known_res);
    pixel_result_t res;
    if (pace_gaps) begin
      while ($urandom_range(0, 99) < 30) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    start = 1'b1;
    pixel_column = col;
    pixel_row = row;
    do @(posedge clk); while (busy);
    res = known ? known_res : predict_pixel(model_cfg, col, row);
    pending_pixels.push_back(res);
    pixels_sent++;
    if (res.member) members_seen++;
    else if (res.count % PaletteSize == 0) wraps_seen++;
    @(negedge clk);
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    while ($urandom_range(0, 99) < 30) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      CFG_CENTER_REAL:    model_cfg.center_real = data;
      CFG_CENTER_IMAG:    model_cfg.center_imag = data;
      CFG_PIXEL_STEP:     model_cfg.pixel_step = data[30:0];
      CFG_IMAGE_WIDTH:    model_cfg.image_width = data[10:0];
      CFG_IMAGE_HEIGHT:   model_cfg.image_height = data[10:0];
      CFG_MAX_ITERATIONS: model_cfg.max_iterations = data[15:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want = pending_pixels.pop_front();
        if (escape_count !== want.count) begin
          $error("escape_count: expected %0d, got %0d", want.count, escape_count);
          failures++;
        end
        if (in_set !== want.member) begin
          $error("in_set: expected %0d, got %0d", want.member, in_set);
          failures++;
        end
        if (red !== want.red) begin
          $error("red: expected %0h, got %0h", want.red, red);
          failures++;
        end
        if (green !== want.green) begin
          $error("green: expected %0h, got %0h", want.green, green);
          failures++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0h, got %0h", want.blue, blue);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("mandelbrot_escape_time_pixel verification failed");
      $finish;
    end
  end

  initial begin
    cfg_t hunt_cfg;
    pixel_result_t probe;
    view_t view;
    logic [31:0] w_cr, w_ci, w_step, w_width, w_height, w_limit;
    logic [9:0] col, row;
    int random_sent;
    int burst;
    int pick;

    model_cfg = '{center_real: -32'sd188519432, center_imag: 32'sd94012716,
                  pixel_step: 31'd1533916, image_width: 11'd700, image_height: 11'd700,
                  max_iterations: 16'd1000};

    // columns on the real axis just right of the cusp whose count lands on a palette wrap
    hunt_cfg = '{center_real: WrapCenter, center_imag: '0, pixel_step: WrapStride[30:0],
                 image_width: WrapSpan[10:0], image_height: WrapSpan[10:0],
                 max_iterations: WrapLimit[15:0]};
    for (int c = 0; c < 1024; c++) begin
      probe = predict_pixel(hunt_cfg, c[9:0], 10'd512);
      if (!probe.member && probe.count % PaletteSize == 0) wrap_cols.push_back(c);
    end

    plan.push_back(plan_pixel(10'd350, 10'd350));
    plan.push_back(plan_pixel(10'd0, 10'd0));
    plan.push_back(plan_pixel(10'd1023, 10'd1023));
    plan.push_back(plan_pixel(10'd1023, 10'd0));
    plan.push_back(plan_pixel(10'd0, 10'd1023));
    plan.push_back(plan_write(CFG_SPARE_LO, 32'hFFFFFFFF));
    plan.push_back(plan_write(CFG_SPARE_HI, 32'h00000000));
    plan.push_back(plan_pixel(10'd350, 10'd0));
    // zero iteration limit
    plan.push_back(plan_write(CFG_MAX_ITERATIONS, 32'd0));
    plan.push_back(plan_known(10'd0, 10'd0, 16'd0, 1'b1, 24'h000000));
    plan.push_back(plan_known(10'd1023, 10'd1023, 16'd0, 1'b1, 24'h000000));
    // extreme centre, zero step: escapes after one iteration
    plan.push_back(plan_write(CFG_CENTER_REAL, 32'h7FFFFFFF));
    plan.push_back(plan_write(CFG_CENTER_IMAG, 32'h80000000));
    plan.push_back(plan_write(CFG_PIXEL_STEP, 32'd0));
    plan.push_back(plan_write(CFG_MAX_ITERATIONS, 32'd2));
    plan.push_back(plan_known(10'd512, 10'd512, 16'd1, 1'b0, 24'hFFB404));
    plan.push_back(plan_known(10'd0, 10'd1023, 16'd1, 1'b0, 24'hFFB404));
    plan.push_back(plan_write(CFG_MAX_ITERATIONS, 32'd1));
    plan.push_back(plan_known(10'd7, 10'd9, 16'd1, 1'b1, 24'h000000));
    // largest step and height, saturating mapping
    plan.push_back(plan_write(CFG_CENTER_REAL, 32'h00000000));
    plan.push_back(plan_write(CFG_CENTER_IMAG, 32'h00000000));
    plan.push_back(plan_write(CFG_PIXEL_STEP, 32'h7FFFFFFF));
    plan.push_back(plan_write(CFG_IMAGE_WIDTH, 32'd1024));
    plan.push_back(plan_write(CFG_IMAGE_HEIGHT, 32'd2047));
    plan.push_back(plan_write(CFG_MAX_ITERATIONS, 32'd40));
    plan.push_back(plan_pixel(10'd1023, 10'd0));
    plan.push_back(plan_pixel(10'd0, 10'd1023));
    plan.push_back(plan_pixel(10'd512, 10'd1023));
    // odd one-pixel image, smallest nonzero step
    plan.push_back(plan_write(CFG_PIXEL_STEP, 32'd1));
    plan.push_back(plan_write(CFG_IMAGE_WIDTH, 32'd1));
    plan.push_back(plan_write(CFG_IMAGE_HEIGHT, 32'd1));
    plan.push_back(plan_pixel(10'd0, 10'd0));
    plan.push_back(plan_pixel(10'd1, 10'd1));
    // full iteration limit: origin never escapes, c = 2 and c = -2 escape at once
    plan.push_back(plan_write(CFG_PIXEL_STEP, 32'd0));
    plan.push_back(plan_write(CFG_MAX_ITERATIONS, 32'd65535));
    plan.push_back(plan_known(10'd100, 10'd200, 16'hFFFF, 1'b1, 24'h000000));
    plan.push_back(plan_write(CFG_CENTER_REAL, 32'h20000000));
    plan.push_back(plan_known(10'd1023, 10'd0, 16'd1, 1'b0, 24'hFFB404));
    plan.push_back(plan_write(CFG_CENTER_REAL, 32'hE0000000));
    plan.push_back(plan_known(10'd0, 10'd0, 16'd1, 1'b0, 24'hFFB404));

    repeat (7) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        issue_pixel(plan[i].px_col, plan[i].px_row, plan[i].known, plan[i].res);
      end
    end

    random_sent = 0;
    while (random_sent < RandomItems) begin
      pick = $urandom_range(0, 3);
      view = (pick < 2) ? VIEW_BOUNDARY : (pick == 2) ? VIEW_RAW : VIEW_WRAP;
      unique case (view)
        VIEW_BOUNDARY: begin
          w_cr = $urandom_range(0, 32'h28000000) - 32'h20000000;
          w_ci = $urandom_range(0, 32'h20000000) - 32'h10000000;
          w_step = $urandom_range(32'h1000, 32'h100000);
          w_width = $urandom_range(1, 1024);
          w_height = $urandom_range(1, 1024);
          w_limit = $urandom_range(1, 250);
        end
        VIEW_RAW: begin
          w_cr = $urandom;
          w_ci = $urandom;
          w_step = $urandom;
          w_width = $urandom;
          w_height = $urandom;
          w_limit = $urandom_range(0, 300);
        end
        default: begin
          w_cr = WrapCenter;
          w_ci = '0;
          w_step = WrapStride;
          w_width = WrapSpan;
          w_height = WrapSpan;
          w_limit = WrapLimit;
        end
      endcase
      settle();
      write_reg(CFG_CENTER_REAL, w_cr);
      write_reg(CFG_CENTER_IMAG, w_ci);
      write_reg(CFG_PIXEL_STEP, w_step);
      write_reg(CFG_IMAGE_WIDTH, w_width);
      write_reg(CFG_IMAGE_HEIGHT, w_height);
      write_reg(CFG_MAX_ITERATIONS, w_limit);

      burst = $urandom_range(10, 40);
      for (int k = 0; k < burst && random_sent < RandomItems; k++) begin
        pace_gaps = !(random_sent >= 250 && random_sent < 350);
        col = 10'($urandom_range(0, 1023));
        row = 10'($urandom_range(0, 1023));
        if (view == VIEW_BOUNDARY && $urandom_range(0, 9) < 8) begin
          col = 10'($urandom_range(0, model_cfg.image_width - 1));
          row = 10'($urandom_range(0, model_cfg.image_height - 1));
        end else if (view == VIEW_WRAP && wrap_cols.size() != 0 && $urandom_range(0, 1)) begin
          col = 10'(wrap_cols[$urandom_range(0, wrap_cols.size() - 1)]);
          row = 10'd512;
        end
        issue_pixel(col, row, 1'b0, '0);
        random_sent++;
      end
    end

    settle();
    repeat (DrainCycles) @(negedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d results never arrived", pending_pixels.size());
      failures++;
    end
    $display("covered %0d pixel requests over %0d register writes", pixels_sent, reg_writes);
    $display("%0d were set members and %0d took the wrapped palette entry",
             members_seen, wraps_seen);
    if (failures == 0) begin
      $display("mandelbrot_escape_time_pixel verification clean");
    end else begin
      $display("mandelbrot_escape_time_pixel verification failed");
    end
    $finish;
  end

endmodule
